// File: sv/csim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity package
// Shared constants, sequencer states and control structs.
// ----------------------------------------------------------------------------
package csim_pkg;

  // Largest vector length that accumulates without clamping.
  localparam int unsigned MAX_ELEMENTS = 4096;

  localparam int AccW  = 44;  // accumulator width
  localparam int MulW  = 22;  // shared multiplier operand width
  localparam int WideW = 88;  // double-width products
  localparam int QuoW  = 30;  // quotient of the squared ratio
  localparam int RootW = 31;  // square root working width
  localparam int CntW  = 5;   // sequencer step counter

  // Accumulator clamp bound: MAX_ELEMENTS * 2^30, capped at 2^43 - 1.
  localparam logic [63:0] BoundRaw = 64'(MAX_ELEMENTS) << 30;
  localparam logic [63:0] AccCap   = (64'd1 << 43) - 64'd1;
  localparam logic [AccW-1:0] ACC_BOUND =
      (BoundRaw > AccCap) ? AccCap[AccW-1:0] : BoundRaw[AccW-1:0];

  // Fixed-point one.
  localparam logic [15:0] ONE_FIX = 16'h8000;

  // Sequencer step limits.
  localparam logic [CntW-1:0] ElemLast = 5'd3;
  localparam logic [CntW-1:0] ProdLast = 5'd8;
  localparam logic [CntW-1:0] DivFirst = 5'd29;
  localparam logic [CntW-1:0] SqrtFirst = 5'd14;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_CHECK,
    ST_PROD,
    ST_CLAMP,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  typedef struct packed {
    state_e          state;
    logic [CntW-1:0] cnt;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic last;
    logic zero_norm;
    logic ge_one;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: sv/cosine_similarity_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity stream
// Accumulates dot product and squared norms, then emits their cosine.
// ----------------------------------------------------------------------------
// An element pair is accepted only while idle; one 22 x 22 multiplier,
// registered, forms a*b, a*a and b*b in turn before the next pair can
// be taken. An item marked last then keeps the block busy until the result
// is presented (zero check, nine multiplier steps for the eight partial
// products of the 88-bit norm product and squared dot, clamp compare, 30
// restoring divide steps, 15 square root steps, output load); divide and
// root are skipped when the ratio reaches one, and all but zero check and
// output load when a norm is zero. The result sits in an output register;
// if it has not been taken, the block holds before writing the next one.
module cosine_similarity_stream (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] elem_a_i,
  input  wire logic signed [15:0] elem_b_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [16:0]      similarity_o,
  output logic                    zero_norm_o,
  output logic                    saturated_o
);

  localparam int AccW  = csim_pkg::AccW;
  localparam int MulW  = csim_pkg::MulW;
  localparam int WideW = csim_pkg::WideW;
  localparam int QuoW  = csim_pkg::QuoW;
  localparam int RootW = csim_pkg::RootW;

  csim_pkg::ctrl_t ctrl;
  csim_pkg::stat_t stat;

  logic [15:0]            a_q, b_q;
  logic                   last_q;
  logic signed [AccW-1:0] dot_q;
  logic [AccW-1:0]        na_q, nb_q;
  logic                   sat_q;
  logic [WideW-1:0]       pn_q, m2_q, rem_q;
  logic [QuoW-1:0]        quo_q, op_q;
  logic [RootW-1:0]       res_q;
  logic [15:0]            q_q;
  logic                   zn_q;
  logic                   out_valid_q;
  logic signed [16:0]     sim_q;
  logic                   zn_out_q, sat_out_q;

  logic [15:0]            a_mag, b_mag;
  logic [AccW-1:0]        m_mag;
  logic [MulW-1:0]        mul_x, mul_y;
  logic [2*MulW-1:0]      mul_p;
  logic [AccW-1:0]        px, py;
  logic [csim_pkg::CntW-1:0] prev;
  logic [WideW-1:0]       pp_sh;
  logic signed [AccW+1:0] pe, dsum, bnd_s;
  logic [AccW:0]          nsum;
  logic [WideW-1:0]       rem2;
  logic                   div_ge;
  logic [QuoW-1:0]        quo_next;
  logic [RootW-1:0]       one, trial, res_next;
  logic                   sq_ge;
  logic                   in_fire, out_free, load_out;

  // Handshake.
  assign in_ready_o = (ctrl.state == csim_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (ctrl.state == csim_pkg::ST_DONE) && out_free;

  assign stat.in_fire   = in_fire;
  assign stat.last      = last_q;
  assign stat.zero_norm = (na_q == '0) || (nb_q == '0);
  assign stat.ge_one    = (m2_q >= pn_q);
  assign stat.out_free  = out_free;

  csim_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Magnitudes of the element pair and of the dot product.
  assign a_mag = a_q[15] ? (~a_q + 16'd1) : a_q;
  assign b_mag = b_q[15] ? (~b_q + 16'd1) : b_q;
  assign m_mag = dot_q[AccW-1] ? AccW'(-dot_q) : AccW'(dot_q);

  // Operand selection for the shared multiplier.
  assign px = (ctrl.cnt < 5'd4) ? na_q : m_mag;
  assign py = (ctrl.cnt < 5'd4) ? nb_q : m_mag;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    if (ctrl.state == csim_pkg::ST_ELEM) begin
      unique case (ctrl.cnt[1:0])
        2'd0: begin mul_x = MulW'(a_mag); mul_y = MulW'(b_mag); end
        2'd1: begin mul_x = MulW'(a_mag); mul_y = MulW'(a_mag); end
        2'd2: begin mul_x = MulW'(b_mag); mul_y = MulW'(b_mag); end
        default: begin mul_x = '0; mul_y = '0; end
      endcase
    end else if (ctrl.state == csim_pkg::ST_PROD) begin
      mul_x = ctrl.cnt[1] ? px[AccW-1:MulW] : px[MulW-1:0];
      mul_y = ctrl.cnt[0] ? py[AccW-1:MulW] : py[MulW-1:0];
    end
  end

  csim_mul u_mul (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .p_o   (mul_p)
  );

  // Partial product alignment: the step before this one chose the halves.
  assign prev = ctrl.cnt - 5'd1;
  always_comb begin
    unique case (prev[1:0])
      2'd0:    pp_sh = WideW'(mul_p);
      2'd3:    pp_sh = WideW'(mul_p) << (2*MulW);
      default: pp_sh = WideW'(mul_p) << MulW;
    endcase
  end

  // Saturating accumulator sums.
  assign bnd_s = $signed({2'b00, csim_pkg::ACC_BOUND});
  assign pe    = $signed({2'b00, mul_p});
  assign dsum  = {{2{dot_q[AccW-1]}}, dot_q} + ((a_q[15] ^ b_q[15]) ? -pe : pe);
  assign nsum  = (ctrl.cnt == 5'd2) ? ({1'b0, na_q} + {1'b0, mul_p})
                                    : ({1'b0, nb_q} + {1'b0, mul_p});

  // One restoring divide step.
  assign rem2     = {rem_q[WideW-2:0], 1'b0};
  assign div_ge   = (rem2 >= pn_q);
  assign quo_next = {quo_q[QuoW-2:0], div_ge};

  // One square root step.
  assign one      = RootW'(1) << {ctrl.cnt, 1'b0};
  assign trial    = res_q + one;
  assign sq_ge    = ({1'b0, op_q} >= trial);
  assign res_next = sq_ge ? ((res_q >> 1) + one) : (res_q >> 1);

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= elem_a_i;
      b_q    <= elem_b_i;
      last_q <= last_i;
    end
  end

  // Accumulators, cleared by reset and after each result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sat_q <= 1'b0;
    end else if (load_out) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sat_q <= 1'b0;
    end else if (ctrl.state == csim_pkg::ST_ELEM) begin
      if (ctrl.cnt == 5'd1) begin
        if (dsum > bnd_s) begin
          dot_q <= $signed(csim_pkg::ACC_BOUND);
          sat_q <= 1'b1;
        end else if (dsum < -bnd_s) begin
          dot_q <= -$signed(csim_pkg::ACC_BOUND);
          sat_q <= 1'b1;
        end else begin
          dot_q <= dsum[AccW-1:0];
        end
      end
      if (ctrl.cnt == 5'd2 || ctrl.cnt == 5'd3) begin
        if (nsum > {1'b0, csim_pkg::ACC_BOUND}) begin
          sat_q <= 1'b1;
        end
        if (ctrl.cnt == 5'd2) begin
          na_q <= (nsum > {1'b0, csim_pkg::ACC_BOUND}) ? csim_pkg::ACC_BOUND
                                                       : nsum[AccW-1:0];
        end else begin
          nb_q <= (nsum > {1'b0, csim_pkg::ACC_BOUND}) ? csim_pkg::ACC_BOUND
                                                       : nsum[AccW-1:0];
        end
      end
    end
  end

  // Final computation: norm product, squared dot, divide and root.
  always_ff @(posedge clk_i) begin
    unique case (ctrl.state)
      csim_pkg::ST_CHECK: begin
        pn_q <= '0;
        m2_q <= '0;
        zn_q <= stat.zero_norm;
        q_q  <= '0;
      end
      csim_pkg::ST_PROD: begin
        if (ctrl.cnt != '0) begin
          if (prev[2]) m2_q <= m2_q + pp_sh;
          else         pn_q <= pn_q + pp_sh;
        end
      end
      csim_pkg::ST_CLAMP: begin
        rem_q <= m2_q;
        quo_q <= '0;
        if (stat.ge_one) q_q <= csim_pkg::ONE_FIX;
      end
      csim_pkg::ST_DIV: begin
        rem_q <= div_ge ? (rem2 - pn_q) : rem2;
        quo_q <= quo_next;
        if (ctrl.cnt == '0) begin
          op_q  <= quo_next;
          res_q <= '0;
        end
      end
      csim_pkg::ST_SQRT: begin
        if (sq_ge) op_q <= op_q - trial[QuoW-1:0];
        res_q <= res_next;
        if (ctrl.cnt == '0) q_q <= res_next[15:0];
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      sim_q     <= dot_q[AccW-1] ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
      zn_out_q  <= zn_q;
      sat_out_q <= sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zn_out_q;
  assign saturated_o  = sat_out_q;

endmodule
`default_nettype wire

// File: sv/csim_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 22 x 22 multiplier with a registered product.
// ----------------------------------------------------------------------------
module csim_mul (
  input  wire logic                         clk_i,
  input  wire logic [csim_pkg::MulW-1:0]    x_i,
  input  wire logic [csim_pkg::MulW-1:0]    y_i,
  output logic      [2*csim_pkg::MulW-1:0]  p_o
);

  logic [2*csim_pkg::MulW-1:0] p_q;

  // The product is registered, so it is available in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= (2*csim_pkg::MulW)'(x_i) * (2*csim_pkg::MulW)'(y_i);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: sv/csim_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity sequencer
// Steps the shared multiplier, divider and square root through each item.
// ----------------------------------------------------------------------------
module csim_fsm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire csim_pkg::stat_t stat_i,
  output csim_pkg::ctrl_t      ctrl_o
);

  csim_pkg::state_e             state_q, state_d;
  logic [csim_pkg::CntW-1:0]    cnt_q, cnt_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csim_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state logic.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      csim_pkg::ST_IDLE: begin
        if (stat_i.in_fire) begin
          state_d = csim_pkg::ST_ELEM;
          cnt_d   = '0;
        end
      end
      csim_pkg::ST_ELEM: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == csim_pkg::ElemLast) begin
          state_d = stat_i.last ? csim_pkg::ST_CHECK : csim_pkg::ST_IDLE;
        end
      end
      csim_pkg::ST_CHECK: begin
        cnt_d   = '0;
        state_d = stat_i.zero_norm ? csim_pkg::ST_DONE : csim_pkg::ST_PROD;
      end
      csim_pkg::ST_PROD: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == csim_pkg::ProdLast) begin
          state_d = csim_pkg::ST_CLAMP;
        end
      end
      csim_pkg::ST_CLAMP: begin
        cnt_d   = csim_pkg::DivFirst;
        state_d = stat_i.ge_one ? csim_pkg::ST_DONE : csim_pkg::ST_DIV;
      end
      csim_pkg::ST_DIV: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = csim_pkg::ST_SQRT;
          cnt_d   = csim_pkg::SqrtFirst;
        end
      end
      csim_pkg::ST_SQRT: begin
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = csim_pkg::ST_DONE;
        end
      end
      csim_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = csim_pkg::ST_IDLE;
        end
      end
      default: state_d = csim_pkg::ST_IDLE;
    endcase
  end

  assign ctrl_o.state = state_q;
  assign ctrl_o.cnt   = cnt_q;

endmodule
`default_nettype wire

// File: sv/csim_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cosine similarity port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module csim_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [16:0] similarity_o,
  input wire logic               zero_norm_o
);

  // A pending result transaction holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(similarity_o))
    else $error("result changed while stalled");

  // A zero norm always gives a zero similarity.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> similarity_o == 17'sd0)
    else $error("zero norm with nonzero similarity");

  // Similarity stays within minus one to plus one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(similarity_o[16] && !similarity_o[15]) &&
      !(!similarity_o[16] && similarity_o[15] && similarity_o[14:0] != 15'd0))
    else $error("similarity out of range");

  // After an input transaction the block is busy for a while.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an input transaction");

endmodule

bind cosine_similarity_stream csim_checker u_csim_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .similarity_o (similarity_o),
  .zero_norm_o  (zero_norm_o)
);
`default_nettype wire
